[hdl/mavg_pkg.sv]
// Shared types and constants for the moving average block.
`default_nettype none

package mavg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ENTRY_W  = 15;

    // Result reported for a failed measurement: -1.0 with 5 fractional bits.
    localparam logic signed [SAMPLE_W-1:0] FAIL_AVG = -16'sd32;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIN,
        ST_DIV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

[hdl/mavg_if.sv]
// Valid/ready channel interfaces for the sample input and the result output.
`default_nettype none

interface mavg_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mavg_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mavg_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [mavg_pkg::SAMPLE_W-1:0]  average;
    logic                                  failed;

    modport source (output valid, output average, output failed, input ready);
    modport sink   (input valid, input average, input failed, output ready);
endinterface

`default_nettype wire

[hdl/mavg_window.sv]
// Window memory with running sum, write index and fill flag.
`default_nettype none

module mavg_window #(
    parameter int WINDOW = 5,
    parameter int IDX_W  = 3,
    parameter int CNT_W  = 3,
    parameter int SUM_W  = 18
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [mavg_pkg::ENTRY_W-1:0]        sample,
    output logic                                     done,
    output logic [SUM_W-1:0]                         sum,
    output logic [CNT_W-1:0]                         count
);

    logic [mavg_pkg::ENTRY_W-1:0] mem [WINDOW];

    logic [mavg_pkg::ENTRY_W-1:0] old_reg;
    logic [mavg_pkg::ENTRY_W-1:0] sample_reg;
    logic                         pend_reg;
    logic                         done_reg;
    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             idx_next;
    logic                         full_reg;
    logic                         full_next;
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;
    logic [SUM_W-1:0]             old_term;

    // Read the entry about to be replaced; its data is registered and ready in the next cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            old_reg    <= mem[idx_reg];
            sample_reg <= sample;
        end
        if (pend_reg)
        begin
            mem[idx_reg] <= sample_reg;
        end
    end

    // The old entry is only meaningful once the window has wrapped.
    assign old_term = full_reg ? SUM_W'(old_reg) : '0;

    always_comb
    begin
        sum_next  = sum_reg;
        idx_next  = idx_reg;
        full_next = full_reg;
        if (pend_reg)
        begin
            sum_next = sum_reg + SUM_W'(sample_reg) - old_term;
            if (idx_reg == IDX_W'(WINDOW - 1))
            begin
                idx_next  = '0;
                full_next = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            full_reg <= 1'b0;
            sum_reg  <= '0;
        end
        else
        begin
            pend_reg <= start;
            done_reg <= pend_reg;
            idx_reg  <= idx_next;
            full_reg <= full_next;
            sum_reg  <= sum_next;
        end
    end

    assign done  = done_reg;
    assign sum   = sum_reg;
    assign count = full_reg ? CNT_W'(WINDOW) : CNT_W'(idx_reg);

endmodule

`default_nettype wire

[hdl/mavg_divider.sv]
// Restoring serial divider, one quotient bit per cycle.
`default_nettype none

module mavg_divider #(
    parameter int SUM_W = 18,
    parameter int CNT_W = 3
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  dividend,
    input  wire logic [CNT_W-1:0]  divisor,
    output logic                   done,
    output logic [SUM_W-1:0]       quotient
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, div_reg};
    assign fits  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
            rem_reg <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(SUM_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[hdl/moving_average_with_fill_count.sv]
// Top level of the moving average with fill count.
// A failed sample skips ahead to the pending result; a valid one first passes
// the window update and the serial divider. One item is in flight at a time: a
// new sample is taken only once the last is loaded into the output register.
// Reset clears the write index, the fill flag and the running sum; the window
// memory needs no clearing since only written entries ever enter the sum.
`default_nettype none

module moving_average_with_fill_count #(
    parameter int WINDOW = 5
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    mavg_in_if.sink     sample_ch,
    mavg_out_if.source  result_ch
);

    // Index and count widths follow the window depth. The running sum needs
    // room for WINDOW full-scale entries.
    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = mavg_pkg::ENTRY_W + CNT_W;

    mavg_pkg::state_t state_reg;
    mavg_pkg::state_t state_next;

    logic                               accept;
    logic                               win_start;
    logic                               win_done;
    logic [SUM_W-1:0]                   win_sum;
    logic [CNT_W-1:0]                   win_count;
    logic                               div_start;
    logic                               div_done;
    logic [SUM_W-1:0]                   div_quo;
    logic                               load_out;

    // Pending result, held until the output register can take it.
    logic signed [mavg_pkg::SAMPLE_W-1:0] res_avg_reg;
    logic signed [mavg_pkg::SAMPLE_W-1:0] res_avg_next;
    logic                                 res_failed_reg;
    logic                                 res_failed_next;

    // Output register: a finished item waits here while the next one is taken.
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [mavg_pkg::SAMPLE_W-1:0] out_avg_reg;
    logic                                 out_failed_reg;

    assign sample_ch.ready = (state_reg == mavg_pkg::ST_IDLE);
    assign accept          = sample_ch.valid && sample_ch.ready;

    mavg_window #(
        .WINDOW (WINDOW),
        .IDX_W  (IDX_W),
        .CNT_W  (CNT_W),
        .SUM_W  (SUM_W)
    ) u_window (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (win_start),
        .sample (sample_ch.sample[mavg_pkg::ENTRY_W-1:0]),
        .done   (win_done),
        .sum    (win_sum),
        .count  (win_count)
    );

    mavg_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (win_sum),
        .divisor  (win_count),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer: a negative sample bypasses the window entirely; a valid one
    // updates the window, then the sum is divided by the current fill count.
    always_comb
    begin
        state_next      = state_reg;
        win_start       = 1'b0;
        div_start       = 1'b0;
        load_out        = 1'b0;
        res_avg_next    = res_avg_reg;
        res_failed_next = res_failed_reg;
        case (state_reg)
            mavg_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample_ch.sample[mavg_pkg::SAMPLE_W-1])
                    begin
                        res_avg_next    = mavg_pkg::FAIL_AVG;
                        res_failed_next = 1'b1;
                        state_next      = mavg_pkg::ST_OUT;
                    end
                    else
                    begin
                        win_start  = 1'b1;
                        state_next = mavg_pkg::ST_WIN;
                    end
                end
            end
            mavg_pkg::ST_WIN:
            begin
                if (win_done)
                begin
                    div_start  = 1'b1;
                    state_next = mavg_pkg::ST_DIV;
                end
            end
            mavg_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    // The mean of 15-bit entries always fits in 15 bits.
                    res_avg_next    = {1'b0, div_quo[mavg_pkg::ENTRY_W-1:0]};
                    res_failed_next = 1'b0;
                    state_next      = mavg_pkg::ST_OUT;
                end
            end
            mavg_pkg::ST_OUT:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    load_out   = 1'b1;
                    state_next = mavg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mavg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mavg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_avg_reg    <= res_avg_next;
        res_failed_reg <= res_failed_next;
        if (load_out)
        begin
            out_avg_reg    <= res_avg_reg;
            out_failed_reg <= res_failed_reg;
        end
    end

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.average = out_avg_reg;
    assign result_ch.failed  = out_failed_reg;

`ifndef SYNTH
    a_fail_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_ch.valid && result_ch.failed |-> result_ch.average == mavg_pkg::FAIL_AVG)
        else $error("failed result without the failure value");

    a_valid_sample_updates: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !sample_ch.sample[mavg_pkg::SAMPLE_W-1] |=> state_reg == mavg_pkg::ST_WIN)
        else $error("valid sample did not start a window update");

    a_win_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        win_done |-> state_reg == mavg_pkg::ST_WIN)
        else $error("window update finished outside its state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == mavg_pkg::ST_DIV)
        else $error("divider finished outside its state");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        win_done |-> win_count != '0)
        else $error("divide by a zero fill count");
`endif

endmodule

`default_nettype wire
